[hw/rtl/rtp_pkg.sv]
package rtp_pkg;

  // Field widths fixed by the item formats.
  localparam int FUNC_W     = 2;
  localparam int LOC_W      = 12;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int FPOS_W     = 12;
  localparam int SHIFT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  // Widest code store address carried between the front and the back.
  localparam int MAX_ADDR_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BSS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZEROPAGE = 2'd3;

  // Segment codes; all but SEG_UNDEF carry a shift register.
  localparam logic [2:0] SEG_UNDEF    = 3'd0;
  localparam logic [2:0] SEG_TEXT     = 3'd2;
  localparam logic [2:0] SEG_DATA     = 3'd3;
  localparam logic [2:0] SEG_BSS      = 3'd4;
  localparam logic [2:0] SEG_ZEROPAGE = 3'd5;

  // Table byte codes.
  localparam logic [BYTE_W-1:0] TYPE_MASK = 8'he0;
  localparam logic [BYTE_W-1:0] SEG_MASK  = 8'h07;
  localparam logic [BYTE_W-1:0] T_WORD    = 8'h80;
  localparam logic [BYTE_W-1:0] T_HIGH    = 8'h40;
  localparam logic [BYTE_W-1:0] T_BYTE    = 8'h20;
  localparam logic [BYTE_W-1:0] END_CODE  = 8'd0;
  localparam logic [BYTE_W-1:0] SKIP_CODE = 8'd255;
  localparam logic [BYTE_W-1:0] SKIP_ADD  = 8'd254;

  // Result kinds.
  localparam logic [KIND_W-1:0] RK_READ = 2'd0;
  localparam logic [KIND_W-1:0] RK_LOW  = 2'd1;
  localparam logic [KIND_W-1:0] RK_END  = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TABLE = 2'd2,
    FUNC_START = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_OFFSET = 2'd0,
    PH_TYPE   = 2'd1,
    PH_LOW    = 2'd2,
    PH_INDEX  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_WORD  = 3'd2,
    OP_HIGH  = 3'd3,
    OP_BYTE  = 3'd4,
    OP_END   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_READ_WAIT = 3'd1,
    ST_BYTE_WB   = 3'd2,
    ST_HIGH_WB   = 3'd3,
    ST_WORD_RD1  = 3'd4,
    ST_WORD_WB0  = 3'd5,
    ST_WORD_WB1  = 3'd6,
    ST_EMIT      = 3'd7
  } back_state_t;

  typedef struct packed {
    func_t             func;
    logic [LOC_W-1:0]  location;
    logic [BYTE_W-1:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] byte_out;
    logic [FPOS_W-1:0] final_position;
  } out_item_t;

  // One store operation handed from the front to the back. For an end of
  // table, addr holds the final position.
  typedef struct packed {
    op_t                   op;
    logic [MAX_ADDR_W-1:0] addr;
    logic [MAX_ADDR_W-1:0] addr1;
    logic [BYTE_W-1:0]     data;
    logic [SHIFT_W-1:0]    shift;
  } cmd_t;

  // Configuration write beat.
  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [SHIFT_W-1:0]   data;
  } cfg_wr_t;

endpackage

[hw/rtl/rtp_fifo.sv]
module rtp_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     head,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  T                 slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/rtp_front.sv]
module rtp_front #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rtp_pkg::in_item_t in_data,
  output logic              full,
  input  rtp_pkg::cfg_wr_t  cfg_wr,
  output logic              cmd_push,
  output rtp_pkg::cmd_t     cmd_data,
  input  logic              cmd_full
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  // Wide enough to hold eight times the depth during location reduction.
  localparam int RED_W  = ADDR_W + 4;
  localparam logic [ADDR_W:0]   DEPTH_W  = (ADDR_W + 1)'(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(STORE_DEPTH - 1);

  logic [rtp_pkg::SHIFT_W-1:0] text_shift_r, data_shift_r, bss_shift_r, zp_shift_r;
  logic [ADDR_W-1:0]           pos_r, pos_nxt;
  rtp_pkg::phase_t             phase_r, phase_nxt;
  logic [2:0]                  seg_r, seg_nxt;
  logic [1:0]                  idx_left_r, idx_left_nxt;

  logic                        accept;
  logic [ADDR_W-1:0]           loc_addr;
  logic [ADDR_W-1:0]           pos_plus_b;
  logic [ADDR_W-1:0]           pos_plus_skip;
  logic [ADDR_W-1:0]           pos_plus_one;
  logic [2:0]                  byte_seg;
  logic [rtp_pkg::BYTE_W-1:0]  byte_type;
  logic [rtp_pkg::MAX_ADDR_W-1:0] pos_wide;

  // Add a small offset to an address, wrapping once past the store end.
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [rtp_pkg::BYTE_W-1:0] b);
    logic [ADDR_W:0] sum;
    sum = (ADDR_W + 1)'(a) + (ADDR_W + 1)'(b);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Reduce a location modulo the depth by restoring subtraction of
  // eight, four, two and one times the depth.
  function automatic logic [ADDR_W-1:0] reduce_loc(input logic [rtp_pkg::LOC_W-1:0] loc);
    logic [RED_W-1:0] r;
    r = RED_W'(loc);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (RED_W'(STORE_DEPTH) << k)) begin
        r = r - (RED_W'(STORE_DEPTH) << k);
      end
    end
    return r[ADDR_W-1:0];
  endfunction

  function automatic logic [rtp_pkg::SHIFT_W-1:0] shift_sel(input logic [2:0] seg,
      input logic [rtp_pkg::SHIFT_W-1:0] t, input logic [rtp_pkg::SHIFT_W-1:0] d,
      input logic [rtp_pkg::SHIFT_W-1:0] b, input logic [rtp_pkg::SHIFT_W-1:0] z);
    logic [rtp_pkg::SHIFT_W-1:0] s;
    case (seg)
      rtp_pkg::SEG_TEXT:     s = t;
      rtp_pkg::SEG_DATA:     s = d;
      rtp_pkg::SEG_BSS:      s = b;
      rtp_pkg::SEG_ZEROPAGE: s = z;
      default:               s = '0;
    endcase
    return s;
  endfunction

  assign full          = cmd_full;
  assign accept        = push && !cmd_full;
  assign loc_addr      = reduce_loc(in_data.location);
  assign pos_plus_b    = wrap_add(pos_r, in_data.byte_in);
  assign pos_plus_skip = wrap_add(pos_r, rtp_pkg::SKIP_ADD);
  assign pos_plus_one  = wrap_add(pos_r, 8'd1);
  assign byte_seg      = 3'(in_data.byte_in & rtp_pkg::SEG_MASK);
  assign byte_type     = in_data.byte_in & rtp_pkg::TYPE_MASK;
  assign pos_wide      = rtp_pkg::MAX_ADDR_W'(pos_r);

  // Classify each accepted beat and walk the table state.
  always_comb begin
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    seg_nxt        = seg_r;
    idx_left_nxt   = idx_left_r;
    cmd_push       = 1'b0;
    cmd_data.op    = rtp_pkg::OP_WRITE;
    cmd_data.addr  = rtp_pkg::MAX_ADDR_W'(loc_addr);
    cmd_data.addr1 = rtp_pkg::MAX_ADDR_W'(pos_plus_one);
    cmd_data.data  = in_data.byte_in;
    cmd_data.shift = '0;
    if (accept) begin
      case (in_data.func)
        rtp_pkg::FUNC_WRITE: begin
          cmd_push    = 1'b1;
          cmd_data.op = rtp_pkg::OP_WRITE;
        end
        rtp_pkg::FUNC_READ: begin
          cmd_push    = 1'b1;
          cmd_data.op = rtp_pkg::OP_READ;
        end
        rtp_pkg::FUNC_START: begin
          pos_nxt      = (loc_addr == '0) ? TOP_ADDR : loc_addr - 1'b1;
          phase_nxt    = rtp_pkg::PH_OFFSET;
          seg_nxt      = '0;
          idx_left_nxt = '0;
        end
        rtp_pkg::FUNC_TABLE: begin
          cmd_data.addr = pos_wide;
          case (phase_r)
            rtp_pkg::PH_OFFSET: begin
              if (in_data.byte_in == rtp_pkg::END_CODE) begin
                cmd_push    = 1'b1;
                cmd_data.op = rtp_pkg::OP_END;
              end else if (in_data.byte_in == rtp_pkg::SKIP_CODE) begin
                pos_nxt = pos_plus_skip;
              end else begin
                pos_nxt   = pos_plus_b;
                phase_nxt = rtp_pkg::PH_TYPE;
              end
            end
            rtp_pkg::PH_TYPE: begin
              seg_nxt        = byte_seg;
              cmd_data.shift = shift_sel(byte_seg, text_shift_r, data_shift_r,
                                         bss_shift_r, zp_shift_r);
              if (byte_type == rtp_pkg::T_HIGH) begin
                phase_nxt = rtp_pkg::PH_LOW;
              end else begin
                if (byte_type == rtp_pkg::T_WORD) begin
                  cmd_push    = 1'b1;
                  cmd_data.op = rtp_pkg::OP_WORD;
                end else if (byte_type == rtp_pkg::T_BYTE) begin
                  cmd_push    = 1'b1;
                  cmd_data.op = rtp_pkg::OP_BYTE;
                end
                // Undefined-label entries are followed by two index bytes.
                if (byte_seg == rtp_pkg::SEG_UNDEF) begin
                  idx_left_nxt = 2'd2;
                  phase_nxt    = rtp_pkg::PH_INDEX;
                end else begin
                  phase_nxt = rtp_pkg::PH_OFFSET;
                end
              end
            end
            rtp_pkg::PH_LOW: begin
              cmd_push       = 1'b1;
              cmd_data.op    = rtp_pkg::OP_HIGH;
              cmd_data.shift = shift_sel(seg_r, text_shift_r, data_shift_r,
                                         bss_shift_r, zp_shift_r);
              if (seg_r == rtp_pkg::SEG_UNDEF) begin
                idx_left_nxt = 2'd2;
                phase_nxt    = rtp_pkg::PH_INDEX;
              end else begin
                phase_nxt = rtp_pkg::PH_OFFSET;
              end
            end
            default: begin
              if (idx_left_r != '0) begin
                idx_left_nxt = idx_left_r - 1'b1;
              end
              if (idx_left_r <= 2'd1) begin
                phase_nxt = rtp_pkg::PH_OFFSET;
              end
            end
          endcase
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      phase_r      <= rtp_pkg::PH_OFFSET;
      seg_r        <= '0;
      idx_left_r   <= '0;
      text_shift_r <= '0;
      data_shift_r <= '0;
      bss_shift_r  <= '0;
      zp_shift_r   <= '0;
    end else begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      seg_r      <= seg_nxt;
      idx_left_r <= idx_left_nxt;
      // Shift registers are written by configuration beats.
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          rtp_pkg::CFG_TEXT:     text_shift_r <= cfg_wr.data;
          rtp_pkg::CFG_DATA:     data_shift_r <= cfg_wr.data;
          rtp_pkg::CFG_BSS:      bss_shift_r  <= cfg_wr.data;
          rtp_pkg::CFG_ZEROPAGE: zp_shift_r   <= cfg_wr.data;
          default:               text_shift_r <= text_shift_r;
        endcase
      end
    end
  end

  // An index phase always has bytes left to skip.
  a_index_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rtp_pkg::PH_INDEX |-> idx_left_r != '0)
    else $error("index phase entered with no bytes left");

  // A start beat always leaves the walker expecting an offset byte.
  a_start_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.func == rtp_pkg::FUNC_START |=>
      phase_r == rtp_pkg::PH_OFFSET && seg_r == '0)
    else $error("start beat did not reset the walker");

  // The position never leaves the store.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ADDR_W + 1)'(pos_r) < DEPTH_W)
    else $error("position beyond the store");

endmodule

[hw/rtl/rtp_back.sv]
module rtp_back #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rtp_pkg::cmd_t      cmd_head,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               res_push,
  output rtp_pkg::out_item_t res_data,
  input  logic               res_full
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  logic [rtp_pkg::BYTE_W-1:0] mem [STORE_DEPTH];
  logic [rtp_pkg::BYTE_W-1:0] rdata_r;

  rtp_pkg::back_state_t       state_r, state_nxt;
  rtp_pkg::cmd_t              cur_r, cur_nxt;
  rtp_pkg::out_item_t         res_r, res_nxt;
  logic [rtp_pkg::BYTE_W-1:0] lo_r, lo_nxt;
  logic [rtp_pkg::BYTE_W-1:0] hi_r, hi_nxt;

  logic                       mem_we, mem_re;
  logic [ADDR_W-1:0]          mem_addr;
  logic [rtp_pkg::BYTE_W-1:0] mem_wdata;
  logic [rtp_pkg::SHIFT_W-1:0] word_sum;
  logic [rtp_pkg::SHIFT_W-1:0] high_sum;

  assign word_sum = {rdata_r, lo_r} + cur_r.shift;
  assign high_sum = {rdata_r, cur_r.data} + cur_r.shift;
  assign res_data = res_r;

  // Sequencer: at most one store access per cycle on the single port.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    res_nxt   = res_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cur_r.addr[ADDR_W-1:0];
    mem_wdata = cur_r.data;
    case (state_r)
      rtp_pkg::ST_IDLE: begin
        mem_addr  = cmd_head.addr[ADDR_W-1:0];
        mem_wdata = cmd_head.data;
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd_head;
          case (cmd_head.op)
            rtp_pkg::OP_WRITE: begin
              mem_we = 1'b1;
            end
            rtp_pkg::OP_READ: begin
              mem_re    = 1'b1;
              state_nxt = rtp_pkg::ST_READ_WAIT;
            end
            rtp_pkg::OP_BYTE: begin
              mem_re    = 1'b1;
              state_nxt = rtp_pkg::ST_BYTE_WB;
            end
            rtp_pkg::OP_HIGH: begin
              mem_re    = 1'b1;
              state_nxt = rtp_pkg::ST_HIGH_WB;
            end
            rtp_pkg::OP_WORD: begin
              mem_re    = 1'b1;
              state_nxt = rtp_pkg::ST_WORD_RD1;
            end
            default: begin
              // End of table: report the final position.
              res_nxt.result_kind    = rtp_pkg::RK_END;
              res_nxt.byte_out       = '0;
              res_nxt.final_position = cmd_head.addr[rtp_pkg::FPOS_W-1:0];
              state_nxt              = rtp_pkg::ST_EMIT;
            end
          endcase
        end
      end
      rtp_pkg::ST_READ_WAIT: begin
        res_nxt.result_kind    = rtp_pkg::RK_READ;
        res_nxt.byte_out       = rdata_r;
        res_nxt.final_position = '0;
        state_nxt              = rtp_pkg::ST_EMIT;
      end
      rtp_pkg::ST_BYTE_WB: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r + cur_r.shift[rtp_pkg::BYTE_W-1:0];
        state_nxt = rtp_pkg::ST_IDLE;
      end
      rtp_pkg::ST_HIGH_WB: begin
        mem_we                 = 1'b1;
        mem_wdata              = high_sum[rtp_pkg::SHIFT_W-1:rtp_pkg::BYTE_W];
        res_nxt.result_kind    = rtp_pkg::RK_LOW;
        res_nxt.byte_out       = high_sum[rtp_pkg::BYTE_W-1:0];
        res_nxt.final_position = '0;
        state_nxt              = rtp_pkg::ST_EMIT;
      end
      rtp_pkg::ST_WORD_RD1: begin
        lo_nxt    = rdata_r;
        mem_re    = 1'b1;
        mem_addr  = cur_r.addr1[ADDR_W-1:0];
        state_nxt = rtp_pkg::ST_WORD_WB0;
      end
      rtp_pkg::ST_WORD_WB0: begin
        mem_we    = 1'b1;
        mem_wdata = word_sum[rtp_pkg::BYTE_W-1:0];
        hi_nxt    = word_sum[rtp_pkg::SHIFT_W-1:rtp_pkg::BYTE_W];
        state_nxt = rtp_pkg::ST_WORD_WB1;
      end
      rtp_pkg::ST_WORD_WB1: begin
        mem_we    = 1'b1;
        mem_addr  = cur_r.addr1[ADDR_W-1:0];
        mem_wdata = hi_r;
        state_nxt = rtp_pkg::ST_IDLE;
      end
      default: begin
        // Hold the result until the result queue has room.
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = rtp_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers carry payload only.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

  // Code store with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // A word patch always runs its two write-backs in turn.
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rtp_pkg::ST_WORD_WB0 |=> state_r == rtp_pkg::ST_WORD_WB1)
    else $error("word patch lost its high write-back");

  // A waiting result stays put while the result queue is full.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rtp_pkg::ST_EMIT && res_full |=>
      state_r == rtp_pkg::ST_EMIT && $stable(res_r))
    else $error("pending result changed under back-pressure");

  // No new command is taken while an operation is in progress.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> state_r == rtp_pkg::ST_IDLE && !cmd_empty)
    else $error("command taken while busy");

endmodule

[hw/rtl/relocation_table_patcher_unit.sv]
// Relocation table patcher. Software writes and reads a byte-wide code store
// and feeds a relocation table one beat at a time; each beat carries func,
// location and byte_in. The front accepts a beat in every cycle while its
// four-entry command queue has room and walks the table position; the back
// then carries out each store operation on the single-port code store, at
// most one access per cycle, and takes no new operation until the last one is
// done. Reads, high-byte patches and table ends each put one result into the
// two-entry result queue, and the back holds a result while that queue is
// full. Results (read data, relocated low bytes and table-end positions)
// leave in order through empty and pop. The shift registers are written
// through the cfg port, which is always ready and must be used only while the
// block is idle. STORE_DEPTH sets the code store size; all addresses wrap
// modulo it, and store entries that were never written read back undefined
// data.
module relocation_table_patcher_unit #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  rtp_pkg::in_item_t               in_data,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output rtp_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtp_pkg::SHIFT_W-1:0]     cfg_data
);

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  rtp_pkg::cfg_wr_t   cfg_wr;
  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
  rtp_pkg::cmd_t      cmd_in, cmd_head;
  logic               res_push, res_full;
  rtp_pkg::out_item_t res_in;

  // Configuration beats are taken in every cycle.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  rtp_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .cfg_wr   (cfg_wr),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  rtp_fifo #(
    .T    (rtp_pkg::cmd_t),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .empty    (cmd_empty)
  );

  rtp_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_head (cmd_head),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res_data (res_in),
    .res_full (res_full)
  );

  rtp_fifo #(
    .T    (rtp_pkg::out_item_t),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_in),
    .full     (res_full),
    .pop      (pop),
    .head     (out_data),
    .empty    (empty)
  );

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_PER_PHASE = 185;
  localparam int NUM_PHASES = 6;
  localparam int REPORT_LIMIT = 10;

  // One beat waiting to be sent, with the result it is predicted to cause.
  typedef struct {
    rtp_pkg::in_item_t  beat;
    bit                 has_res;
    rtp_pkg::out_item_t res;
    bit                 hold;
  } pend_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          push = 1'b0;
  rtp_pkg::in_item_t             in_data = '0;
  logic                          full;
  logic                          empty;
  logic                          pop = 1'b0;
  rtp_pkg::out_item_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rtp_pkg::SHIFT_W-1:0]   cfg_data = '0;

  relocation_table_patcher_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: the code store, which entries hold known data, the walker
  // and the shift registers.
  logic [7:0]          store_m [4096];
  bit                  written [4096];
  logic [11:0]         walk_pos;
  rtp_pkg::phase_t     walk_phase;
  logic [2:0]          walk_seg;
  logic [1:0]          walk_idx;
  logic [15:0]         shift_m [4];

  pend_t               pend_beats [$];
  rtp_pkg::out_item_t  due_results [$];
  pend_t               cur;
  int                  results_owed = 0;
  int                  beats_made = 0;
  int                  errors = 0;
  int                  snd_idle_pct = 0;
  int                  rcv_idle_pct = 0;
  bit                  hold_next = 1'b0;

  function automatic logic [15:0] seg_shift(input logic [2:0] seg);
    case (seg)
      rtp_pkg::SEG_TEXT:     return shift_m[rtp_pkg::CFG_TEXT];
      rtp_pkg::SEG_DATA:     return shift_m[rtp_pkg::CFG_DATA];
      rtp_pkg::SEG_BSS:      return shift_m[rtp_pkg::CFG_BSS];
      rtp_pkg::SEG_ZEROPAGE: return shift_m[rtp_pkg::CFG_ZEROPAGE];
      default:               return '0;
    endcase
  endfunction

  // After a patch, undefined-label entries still carry two index bytes.
  function automatic void close_entry();
    if (walk_seg == rtp_pkg::SEG_UNDEF) begin
      walk_idx = 2'd2;
      walk_phase = rtp_pkg::PH_INDEX;
    end else begin
      walk_phase = rtp_pkg::PH_OFFSET;
    end
  endfunction

  // Applies one beat to the predictor and returns whether it yields a result.
  function automatic bit walk_predict(input rtp_pkg::in_item_t beat,
                                      output rtp_pkg::out_item_t res);
    logic [15:0] acc;
    logic [11:0] nxt;
    logic [7:0]  b;
    logic [7:0]  ty;
    bit          got;
    res = '0;
    got = 1'b0;
    b = beat.byte_in;
    ty = b & rtp_pkg::TYPE_MASK;
    nxt = walk_pos + 12'd1;
    case (beat.func)
      rtp_pkg::FUNC_WRITE: store_m[beat.location] = b;
      rtp_pkg::FUNC_READ: begin
        res.result_kind = rtp_pkg::RK_READ;
        res.byte_out = store_m[beat.location];
        got = 1'b1;
      end
      rtp_pkg::FUNC_START: begin
        walk_pos = beat.location - 12'd1;
        walk_phase = rtp_pkg::PH_OFFSET;
        walk_seg = rtp_pkg::SEG_UNDEF;
        walk_idx = '0;
      end
      default: begin
        case (walk_phase)
          rtp_pkg::PH_OFFSET: begin
            if (b == rtp_pkg::END_CODE) begin
              res.result_kind = rtp_pkg::RK_END;
              res.final_position = walk_pos;
              got = 1'b1;
            end else if (b == rtp_pkg::SKIP_CODE) begin
              walk_pos = walk_pos + 12'(rtp_pkg::SKIP_ADD);
            end else begin
              walk_pos = walk_pos + 12'(b);
              walk_phase = rtp_pkg::PH_TYPE;
            end
          end
          rtp_pkg::PH_TYPE: begin
            walk_seg = 3'(b & rtp_pkg::SEG_MASK);
            if (ty == rtp_pkg::T_WORD) begin
              acc = {store_m[nxt], store_m[walk_pos]} + seg_shift(walk_seg);
              store_m[walk_pos] = acc[7:0];
              store_m[nxt] = acc[15:8];
              close_entry();
            end else if (ty == rtp_pkg::T_HIGH) begin
              walk_phase = rtp_pkg::PH_LOW;
            end else if (ty == rtp_pkg::T_BYTE) begin
              acc = {8'h00, store_m[walk_pos]} + seg_shift(walk_seg);
              store_m[walk_pos] = acc[7:0];
              close_entry();
            end else begin
              close_entry();
            end
          end
          rtp_pkg::PH_LOW: begin
            acc = {store_m[walk_pos], b} + seg_shift(walk_seg);
            store_m[walk_pos] = acc[15:8];
            close_entry();
            res.result_kind = rtp_pkg::RK_LOW;
            res.byte_out = acc[7:0];
            got = 1'b1;
          end
          default: begin
            if (walk_idx != 0) walk_idx = walk_idx - 2'd1;
            if (walk_idx == 0) walk_phase = rtp_pkg::PH_OFFSET;
          end
        endcase
      end
    endcase
    return got;
  endfunction

  task automatic queue_beat(input rtp_pkg::in_item_t beat);
    pend_t p;
    p.beat = beat;
    p.has_res = walk_predict(beat, p.res);
    p.hold = hold_next;
    hold_next = 1'b0;
    if (beat.func == rtp_pkg::FUNC_WRITE) written[beat.location] = 1'b1;
    pend_beats.push_back(p);
    beats_made++;
  endtask

  // Store entries are given known data before anything can read them.
  task automatic make_known(input logic [11:0] addr);
    rtp_pkg::in_item_t beat;
    if (!written[addr]) begin
      beat.func = rtp_pkg::FUNC_WRITE;
      beat.location = addr;
      beat.byte_in = 8'($urandom_range(255));
      queue_beat(beat);
    end
  endtask

  task automatic send_beat(input rtp_pkg::func_t f, input logic [11:0] loc,
                           input logic [7:0] b);
    rtp_pkg::in_item_t beat;
    beat.func = f;
    beat.location = loc;
    beat.byte_in = b;
    if (f == rtp_pkg::FUNC_READ) make_known(loc);
    if (f == rtp_pkg::FUNC_TABLE &&
        (walk_phase == rtp_pkg::PH_TYPE || walk_phase == rtp_pkg::PH_LOW)) begin
      make_known(walk_pos);
      make_known(walk_pos + 12'd1);
    end
    queue_beat(beat);
  endtask

  task automatic send_table(input logic [7:0] b);
    send_beat(rtp_pkg::FUNC_TABLE, 12'($urandom_range(4095)), b);
  endtask

  // A well-formed table walk with random content; now and then it is cut short.
  task automatic gen_table_walk();
    int          n_entries;
    int          r;
    logic [7:0]  ty;
    logic [2:0]  seg;
    send_beat(rtp_pkg::FUNC_START, 12'($urandom_range(4095)), 8'($urandom_range(255)));
    n_entries = $urandom_range(1, 4);
    for (int k = 0; k < n_entries; k++) begin
      if ($urandom_range(9) == 0) send_table(rtp_pkg::SKIP_CODE);
      if ($urandom_range(9) == 0)
        send_beat(rtp_pkg::func_t'($urandom_range(1)), 12'($urandom_range(4095)),
                  8'($urandom_range(255)));
      send_table(8'($urandom_range(1, 254)));
      r = $urandom_range(9);
      seg = 3'($urandom_range(7));
      if (r <= 2) ty = rtp_pkg::T_WORD;
      else if (r <= 5) ty = rtp_pkg::T_HIGH;
      else if (r <= 7) ty = rtp_pkg::T_BYTE;
      else ty = {3'($urandom_range(7)), 5'b0};
      send_table(ty | {3'b000, 2'($urandom_range(3)), seg});
      if ((ty & rtp_pkg::TYPE_MASK) == rtp_pkg::T_HIGH) send_table(8'($urandom_range(255)));
      if (seg == rtp_pkg::SEG_UNDEF) begin
        send_table(8'($urandom_range(255)));
        send_table(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(7) != 0) send_table(rtp_pkg::END_CODE);
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++)
      send_beat(rtp_pkg::func_t'($urandom_range(3)), 12'($urandom_range(4095)),
                8'($urandom_range(255)));
  endtask

  task automatic gen_random(input int n);
    int stop;
    int mid;
    stop = beats_made + n;
    mid = beats_made + n / 2;
    while (beats_made < stop) begin
      if (beats_made >= mid && mid != 0) begin
        hold_next = 1'b1;
        mid = 0;
      end
      if ($urandom_range(99) < 70) gen_table_walk();
      else gen_noise();
    end
  endtask

  task automatic gen_directed();
    send_beat(rtp_pkg::FUNC_WRITE, 12'h000, 8'h00);
    send_beat(rtp_pkg::FUNC_WRITE, 12'hfff, 8'hff);
    send_beat(rtp_pkg::FUNC_READ, 12'h000, 8'h00);
    send_beat(rtp_pkg::FUNC_READ, 12'hfff, 8'hff);
    // A start at the bottom of the store wraps the position to the top.
    send_beat(rtp_pkg::FUNC_START, 12'h000, 8'h00);
    send_table(8'h01);
    send_table(rtp_pkg::T_WORD | {5'b00000, rtp_pkg::SEG_TEXT});
    send_table(rtp_pkg::SKIP_CODE);
    send_table(8'h01);
    send_table(rtp_pkg::T_HIGH | {5'b00000, rtp_pkg::SEG_DATA});
    send_table(8'hff);
    // An undefined-label entry and its two index bytes.
    send_table(8'h02);
    send_table(rtp_pkg::T_BYTE | {5'b00000, rtp_pkg::SEG_UNDEF});
    send_table(8'h12);
    send_table(8'h34);
    send_table(8'h01);
    send_beat(rtp_pkg::FUNC_READ, 12'h000, 8'h5a);
    // Unknown type code with segment 7 patches nothing.
    send_table(8'he7);
    send_table(rtp_pkg::END_CODE);
    // Table bytes after the end carry on from the current position.
    send_table(8'h03);
    send_table(rtp_pkg::T_BYTE | {5'b00000, rtp_pkg::SEG_ZEROPAGE});
    send_table(8'h05);
    send_table(rtp_pkg::T_WORD | {5'b00000, rtp_pkg::SEG_BSS});
    // A start in the middle of an entry drops the entry.
    send_table(8'h10);
    send_beat(rtp_pkg::FUNC_START, 12'hfff, 8'h00);
    send_table(rtp_pkg::END_CODE);
    send_beat(rtp_pkg::FUNC_READ, 12'h001, 8'h00);
  endtask

  task automatic cfg_write(input logic [rtp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtp_pkg::SHIFT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shift_m[idx] = val;
  endtask

  task automatic apply_shifts(input logic [15:0] t, input logic [15:0] d,
                              input logic [15:0] b, input logic [15:0] z);
    cfg_write(rtp_pkg::CFG_TEXT, t);
    cfg_write(rtp_pkg::CFG_DATA, d);
    cfg_write(rtp_pkg::CFG_BSS, b);
    cfg_write(rtp_pkg::CFG_ZEROPAGE, z);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pend_beats.size() != 0 || push || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: one beat is held on the input until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_data <= '0;
      results_owed = 0;
    end else begin
      if (push && !full && cur.has_res) begin
        due_results.push_back(cur.res);
        results_owed++;
      end
      if (pop && !empty) results_owed--;
      if (!(push && full)) begin
        if (pend_beats.size() != 0 && $urandom_range(99) >= snd_idle_pct &&
            !(pend_beats[0].hold && results_owed != 0)) begin
          cur = pend_beats.pop_front();
          in_data <= cur.beat;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("Unexpected result beat: kind %0d byte %02h pos %03h",
                     out_data.result_kind, out_data.byte_out, out_data.final_position);
        end else if (out_data.result_kind !== due_results[0].result_kind ||
                     out_data.byte_out !== due_results[0].byte_out ||
                     out_data.final_position !== due_results[0].final_position) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display({"Mismatch: expected kind %0d byte %02h pos %03h, ",
                      "got kind %0d byte %02h pos %03h"},
                     due_results[0].result_kind, due_results[0].byte_out,
                     due_results[0].final_position, out_data.result_kind,
                     out_data.byte_out, out_data.final_position);
          void'(due_results.pop_front());
        end else begin
          void'(due_results.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    walk_pos = '0;
    walk_phase = rtp_pkg::PH_OFFSET;
    walk_seg = rtp_pkg::SEG_UNDEF;
    walk_idx = '0;
    for (int i = 0; i < 4; i++) shift_m[i] = '0;
    for (int i = 0; i < 4096; i++) begin
      store_m[i] = '0;
      written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_shifts(16'h0001, 16'hffff, 16'h8000, 16'h00ff);
        1: apply_shifts(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        3: apply_shifts(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: apply_shifts(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535)));
      endcase
      @(negedge clk);
      // Receiver-heavy stalls first, then sender-heavy gaps, then none.
      if (p < 2) begin
        snd_idle_pct = 7;
        rcv_idle_pct = 78;
      end else if (p < 4) begin
        snd_idle_pct = 78;
        rcv_idle_pct = 7;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (p == 0) gen_directed();
      gen_random(RANDOM_PER_PHASE);
      wait_drained();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
